// ===== rtl/core/rpnp_pkg.sv =====
// ============================================================================
// rpnp_pkg: shared types and constants of the prefixed number parser
// Request payload types, status codes, radix codes and range limits.
// ============================================================================
`default_nettype none

package rpnp_pkg;

	// One input request: a character and the end-of-literal mark.
	typedef struct packed {
		logic [7:0] char_code;
		logic       is_last;
	} rpnp_in_t;

	// One result request: the parsed value and its status.
	typedef struct packed {
		logic [31:0] value_bits;
		logic [1:0]  status;
	} rpnp_out_t;

	// Result status codes.
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_RANGE     = 2'd1;
	localparam logic [1:0] ST_BAD_FORMAT = 2'd2;

	// Radix selection.
	typedef enum logic [1:0] {
		RX_DEC = 2'd0,
		RX_BIN = 2'd1,
		RX_HEX = 2'd2
	} rpnp_radix_t;

	// Parse phase, one-hot.
	typedef enum logic [4:0] {
		PH_START  = 5'b00001,
		PH_SIGN   = 5'b00010,
		PH_PREFIX = 5'b00100,
		PH_DIGITS = 5'b01000,
		PH_DONE   = 5'b10000
	} rpnp_phase_t;

	// Accumulator width and range limits.
	localparam int unsigned MagW = 33;
	localparam logic [MagW-1:0] MAG_MAX = 33'h1_FFFF_FFFF;
	localparam logic [MagW-1:0] NEG_MAX = 33'h0_8000_0000;

	// Characters with a special meaning at the start of a literal.
	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_DOLLAR  = 8'h24;
	localparam logic [7:0] CH_MINUS   = 8'h2D;

endpackage

`default_nettype wire

// ===== rtl/core/radix_prefixed_number_parser.sv =====
// ============================================================================
// radix_prefixed_number_parser: streaming integer literal parser
// Parses '%' binary, '$' hexadecimal and signed decimal literals.
// ============================================================================
// Usage:
// The input channel (in_valid, in_ready, in_data) takes one character request
// per cycle, first character first; in_data.is_last marks the final character
// of a literal. The output channel (out_valid, out_ready, out_data) gives one
// result request for each literal, on its last character: a 32-bit value
// (two's complement for negatives, zero on error) and a status of ok, out of
// range or invalid format. Characters after the first non-digit are ignored.
// The last character is held in the input register and its result is then
// loaded into the result register. Throughput: one character per cycle while
// in_ready is high, with a combinational shift-and-add update of the 33-bit
// accumulator between the input register and the result register.
// Reset clears the valid flags of the input and result registers and the
// parse state, so the block starts a fresh literal. When the receiver stalls,
// the result register holds its request; characters that are not last keep
// flowing through the input register, and once a last character reaches it
// in_ready drops until out_ready frees the result.
// ============================================================================
`default_nettype none

module radix_prefixed_number_parser
	import rpnp_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire rpnp_in_t  in_data,
	output logic           out_valid,
	input  wire logic      out_ready,
	output rpnp_out_t      out_data
);

	// Input register stage.
	logic        valid_s1;
	rpnp_in_t    data_s1;

	// Parse state.
	rpnp_phase_t phase_q;
	rpnp_radix_t radix_q;
	logic [MagW-1:0] mag_q;
	logic        neg_q;
	logic        ovf_q;
	logic        seen_q;

	// Result register.
	logic        out_valid_q;
	rpnp_out_t   out_data_q;

	// Next-state and decode signals.
	rpnp_phase_t phase_d;
	rpnp_radix_t radix_d;
	rpnp_radix_t radix_eff;
	logic [MagW-1:0] mag_d;
	logic        neg_d;
	logic        ovf_d;
	logic        seen_d;
	logic [7:0]  up_char;
	logic        is_num;
	logic        is_hex_letter;
	logic        digit_ok;
	logic [3:0]  digit_val;
	logic [MagW+3:0] product;
	logic [MagW+4:0] sum;
	logic        do_acc;
	rpnp_out_t   result;
	logic        out_free;
	logic        advance_s1;
	logic        load_out;

	// Handshake: the input stage advances unless it holds a last character
	// and the result register cannot take it.
	assign out_free   = !out_valid_q || out_ready;
	assign advance_s1 = valid_s1 && (!data_s1.is_last || out_free);
	assign load_out   = advance_s1 && data_s1.is_last;
	assign in_ready   = !valid_s1 || advance_s1;
	assign out_valid  = out_valid_q;
	assign out_data   = out_data_q;

	// Character classification in the radix that applies to this character.
	always_comb begin
		if (data_s1.char_code >= 8'h61 && data_s1.char_code <= 8'h7A) begin
			up_char = data_s1.char_code - 8'd32;
		end else begin
			up_char = data_s1.char_code;
		end
		is_num        = (up_char >= 8'h30) && (up_char <= 8'h39);
		is_hex_letter = (up_char >= 8'h41) && (up_char <= 8'h46);
		digit_val     = is_num ? up_char[3:0] : up_char[3:0] + 4'd9;
		radix_eff     = (phase_q == PH_START) ? RX_DEC : radix_q;
		case (radix_eff)
			RX_BIN: begin
				digit_ok = is_num && (up_char[3:1] == 3'd0);
			end
			RX_HEX: begin
				digit_ok = is_num || is_hex_letter;
			end
			default: begin
				digit_ok = is_num;
			end
		endcase
	end

	// Accumulator step: multiply by the radix with shifts and adds.
	always_comb begin
		case (radix_eff)
			RX_BIN: begin
				product = {3'd0, mag_q, 1'b0};
			end
			RX_HEX: begin
				product = {mag_q, 4'd0};
			end
			default: begin
				product = {1'b0, mag_q, 3'd0} + {3'd0, mag_q, 1'b0};
			end
		endcase
		sum = {1'b0, product} + {{(MagW+1){1'b0}}, digit_val};
	end

	// Phase transitions and state update for the character in the input stage.
	always_comb begin
		phase_d = phase_q;
		radix_d = radix_q;
		neg_d   = neg_q;
		do_acc  = 1'b0;
		case (phase_q)
			PH_START: begin
				if (data_s1.char_code == CH_PERCENT) begin
					radix_d = RX_BIN;
					phase_d = PH_PREFIX;
				end else if (data_s1.char_code == CH_DOLLAR) begin
					radix_d = RX_HEX;
					phase_d = PH_PREFIX;
				end else if (data_s1.char_code == CH_MINUS) begin
					radix_d = RX_DEC;
					neg_d   = 1'b1;
					phase_d = PH_SIGN;
				end else begin
					radix_d = RX_DEC;
					do_acc  = digit_ok;
					phase_d = digit_ok ? PH_DIGITS : PH_DONE;
				end
			end
			PH_SIGN, PH_PREFIX, PH_DIGITS: begin
				do_acc  = digit_ok;
				phase_d = digit_ok ? PH_DIGITS : PH_DONE;
			end
			default: begin
				phase_d = phase_q;
			end
		endcase

		mag_d  = mag_q;
		ovf_d  = ovf_q;
		seen_d = seen_q;
		if (do_acc) begin
			seen_d = 1'b1;
			if (ovf_q || (sum[MagW+4:MagW] != 5'd0)) begin
				ovf_d = 1'b1;
				mag_d = MAG_MAX;
			end else begin
				mag_d = sum[MagW-1:0];
			end
		end
	end

	// Result formation from the updated state.
	always_comb begin
		result.value_bits = 32'd0;
		if (!seen_d) begin
			result.status = ST_BAD_FORMAT;
		end else if (ovf_d) begin
			result.status = ST_RANGE;
		end else if (neg_d) begin
			if (mag_d > NEG_MAX) begin
				result.status = ST_RANGE;
			end else begin
				result.value_bits = 32'd0 - mag_d[31:0];
				result.status     = ST_OK;
			end
		end else if (mag_d[MagW-1]) begin
			result.status = ST_RANGE;
		end else begin
			result.value_bits = mag_d[31:0];
			result.status     = ST_OK;
		end
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			phase_q     <= PH_START;
			radix_q     <= RX_DEC;
			mag_q       <= '0;
			neg_q       <= 1'b0;
			ovf_q       <= 1'b0;
			seen_q      <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (advance_s1) begin
				if (data_s1.is_last) begin
					phase_q <= PH_START;
					radix_q <= RX_DEC;
					mag_q   <= '0;
					neg_q   <= 1'b0;
					ovf_q   <= 1'b0;
					seen_q  <= 1'b0;
				end else begin
					phase_q <= phase_d;
					radix_q <= radix_d;
					mag_q   <= mag_d;
					neg_q   <= neg_d;
					ovf_q   <= ovf_d;
					seen_q  <= seen_d;
				end
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= in_data;
		end
		if (load_out) begin
			out_data_q <= result;
		end
	end

	// A result always leaves the parse state at the start of a fresh literal.
	assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> (phase_q == PH_START) && !seen_q && !ovf_q && !neg_q)
		else $error("parse state not cleared after a result");

	// A saturated accumulator holds all ones.
	assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> (mag_q == MAG_MAX))
		else $error("overflow flag set without saturated accumulator");

	// Digits are only seen once the literal is in or past its digit phase.
	assert property (@(posedge clk) disable iff (!arst_n)
		seen_q |-> ((phase_q == PH_DIGITS) || (phase_q == PH_DONE)))
		else $error("digit seen outside digit phases");

	// The input stage only stalls while it holds a last character.
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && data_s1.is_last && out_valid_q && !out_ready))
		else $error("input stalled without a blocked result");

	// A delivered error result carries a zero value.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_data_q.status != ST_OK)) |-> (out_data_q.value_bits == 32'd0))
		else $error("error result with non-zero value");

endmodule

`default_nettype wire

// ===== sim/tb_radix_prefixed_number_parser.sv =====
// ============================================================================
// tb_radix_prefixed_number_parser: self-checking bench of the literal parser
// Sends literals one character request at a time over the input channel and
// checks every result request against a parser model held in the bench.
// Directed tests cover literals without digits, each radix with both letter
// cases, and where a literal stops. Random literals then mix well-formed
// numbers, boundary values, noise and broken prefixes. The sender works in
// bursts with random gaps, and the receiver stalls on a changing pattern.
// ============================================================================
`timescale 1ns / 100ps

module tb_radix_prefixed_number_parser;
	import rpnp_pkg::*;

	// Receiver stall patterns.
	typedef enum int {
		RCV_ALWAYS,
		RCV_HALF,
		RCV_SPARSE,
		RCV_LONG_STALL
	} rcv_mode_t;

	// Random literal kinds.
	typedef enum int {
		LIT_DEC,
		LIT_BIN,
		LIT_HEX,
		LIT_NOISE,
		LIT_BROKEN
	} lit_kind_t;

	localparam int unsigned RANDOM_CHARS = 450;
	localparam int unsigned DRAIN_LIMIT  = 4000;
	localparam int unsigned TAIL_CYCLES  = 8;

	logic      clk;
	logic      arst_n    = 1'b0;
	logic      in_valid  = 1'b0;
	logic      in_ready;
	rpnp_in_t  in_data   = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	rpnp_out_t out_data;

	// Parser state of the bench model.
	rpnp_phase_t     lit_phase = PH_START;
	rpnp_radix_t     lit_radix = RX_DEC;
	logic [MagW-1:0] lit_mag   = '0;
	logic            lit_neg   = 1'b0;
	logic            lit_ovf   = 1'b0;
	logic            lit_seen  = 1'b0;

	// Results still owed by the block, oldest first.
	rpnp_out_t literal_values_q[$];
	rpnp_out_t want_res;

	int unsigned n_errors  = 0;
	int unsigned n_chars   = 0;
	int unsigned n_results = 0;
	int unsigned n_ok      = 0;
	int unsigned n_range   = 0;
	int unsigned n_bad     = 0;
	int unsigned burst_left = 0;

	rcv_mode_t   rcv_mode = RCV_ALWAYS;
	int unsigned rcv_left = 0;

	radix_prefixed_number_parser i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Overall time limit on the run.
	initial begin
		#5_000_000;
		$display("tb_radix_prefixed_number_parser: done, errors");
		$finish;
	end

	// Prints one mismatch line and counts it.
	task automatic report_mismatch(input string msg);
		$display("%0t ERROR %s", $realtime, msg);
		n_errors++;
	endtask

	// Value of a character as a digit of the given radix, or -1.
	function automatic int digit_of(input logic [7:0] ch, input rpnp_radix_t rx);
		int up;
		int lim;
		int d;
		up = ch;
		if (up >= "a" && up <= "z")
			up -= 32;
		lim = (rx == RX_BIN) ? 2 : (rx == RX_HEX) ? 16 : 10;
		if (up >= "0" && up <= "9")
			d = up - "0";
		else if (up >= "A" && up <= "F")
			d = up - "A" + 10;
		else
			d = -1;
		if (d >= lim)
			d = -1;
		return d;
	endfunction

	// Adds one digit to the accumulated magnitude, saturating on overflow.
	function automatic void add_digit(input int d);
		logic [63:0] nxt;
		logic [63:0] base;
		base = (lit_radix == RX_BIN) ? 64'd2 : (lit_radix == RX_HEX) ? 64'd16 : 64'd10;
		nxt  = {31'b0, lit_mag} * base + 64'(d);
		if (lit_ovf || nxt > {31'b0, MAG_MAX}) begin
			lit_ovf = 1'b1;
			lit_mag = MAG_MAX;
		end else begin
			lit_mag = nxt[MagW-1:0];
		end
		lit_seen = 1'b1;
	endfunction

	// Updates the parser model with one accepted character and, on the last
	// character, queues the value the block should give.
	function automatic void parse_char(input rpnp_in_t item);
		int        d;
		rpnp_out_t res;
		case (lit_phase)
			PH_START: begin
				if (item.char_code == CH_PERCENT) begin
					lit_radix = RX_BIN;
					lit_phase = PH_PREFIX;
				end else if (item.char_code == CH_DOLLAR) begin
					lit_radix = RX_HEX;
					lit_phase = PH_PREFIX;
				end else if (item.char_code == CH_MINUS) begin
					lit_radix = RX_DEC;
					lit_neg   = 1'b1;
					lit_phase = PH_SIGN;
				end else begin
					lit_radix = RX_DEC;
					d = digit_of(item.char_code, lit_radix);
					if (d >= 0) begin
						add_digit(d);
						lit_phase = PH_DIGITS;
					end else begin
						lit_phase = PH_DONE;
					end
				end
			end
			PH_SIGN, PH_PREFIX, PH_DIGITS: begin
				d = digit_of(item.char_code, lit_radix);
				if (d >= 0) begin
					add_digit(d);
					lit_phase = PH_DIGITS;
				end else begin
					lit_phase = PH_DONE;
				end
			end
			default: ;
		endcase

		if (item.is_last) begin
			res.value_bits = '0;
			if (!lit_seen) begin
				res.status = ST_BAD_FORMAT;
			end else if (lit_ovf) begin
				res.status = ST_RANGE;
			end else if (lit_neg) begin
				if (lit_mag > NEG_MAX) begin
					res.status = ST_RANGE;
				end else begin
					res.value_bits = ~lit_mag[31:0] + 32'd1;
					res.status     = ST_OK;
				end
			end else if (lit_mag[MagW-1]) begin
				res.status = ST_RANGE;
			end else begin
				res.value_bits = lit_mag[31:0];
				res.status     = ST_OK;
			end
			literal_values_q.insert(literal_values_q.size(), res);

			// A new literal starts from the reset state.
			lit_phase = PH_START;
			lit_radix = RX_DEC;
			lit_mag   = '0;
			lit_neg   = 1'b0;
			lit_ovf   = 1'b0;
			lit_seen  = 1'b0;
		end
	endfunction

	// Sends one character request and waits for its acceptance. Between
	// bursts valid is dropped for a random number of cycles.
	task automatic send_char(input logic [7:0] ch, input logic last);
		rpnp_in_t item;
		int unsigned gap;
		item.char_code = ch;
		item.is_last   = last;
		in_valid <= 1'b1;
		in_data  <= item;
		do
			@(posedge clk);
		while (!in_ready);
		parse_char(item);
		n_chars++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = $urandom_range(1, 6);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(3) == 0) ? $urandom_range(30, 80) :
				$urandom_range(0, 12);
		end
	endtask

	// Sends a whole literal, marking its final character.
	task automatic send_bytes(input logic [7:0] lit[$]);
		for (int i = 0; i < lit.size(); i++)
			send_char(lit[i], i == lit.size() - 1);
	endtask

	task automatic send_text(input string s);
		logic [7:0] lit[$];
		for (int i = 0; i < s.len(); i++)
			lit.insert(lit.size(), s[i]);
		send_bytes(lit);
	endtask

	// Literals that hold no digit at all, including bare prefixes and a sign
	// followed by a radix prefix.
	task automatic test_no_digits();
		send_text("%");
		send_text("$");
		send_text("-");
		send_text("-%");
		send_text("-$");
		send_text("x");
		send_char(8'h00, 1'b1);
		send_char(8'hFF, 1'b1);
	endtask

	// Short literals in each radix, with minus zero and mixed letter case.
	task automatic test_radix_digits();
		send_text("0");
		send_text("-0");
		send_text("%1");
		send_text("$aF");
		send_text("9");
	endtask

	// A character outside the radix ends the literal; the rest is ignored.
	task automatic test_literal_end();
		send_text("$1g");
		send_text("%12");
		send_text("7-");
	endtask

	// Random literals: mostly well-formed numbers with random content and
	// boundary values, the rest noise, broken prefixes and trailing junk.
	task automatic test_random_literals();
		logic [7:0]      lit[$];
		lit_kind_t       kind;
		int unsigned     pick;
		int unsigned     len;
		int unsigned     d;
		int unsigned     stop_at;
		longint unsigned v;
		string           s;
		longint unsigned dec_edges[10] = '{64'd0, 64'd1, 64'd2147483647,
			64'd2147483648, 64'd2147483649, 64'd4294967295, 64'd4294967296,
			64'd8589934591, 64'd8589934592, 64'd99999999999};
		longint unsigned hex_edges[6] = '{64'h7FFFFFFF, 64'h80000000, 64'hFFFFFFFF,
			64'h100000000, 64'h1FFFFFFFF, 64'h200000000};

		stop_at = n_chars + RANDOM_CHARS;
		while (n_chars < stop_at) begin
			lit.delete();
			pick = $urandom_range(0, 9);
			kind = (pick <= 2) ? LIT_DEC : (pick <= 4) ? LIT_BIN : (pick <= 7) ? LIT_HEX :
				(pick == 8) ? LIT_NOISE : LIT_BROKEN;
			case (kind)
				LIT_DEC: begin
					if ($urandom_range(2) == 0)
						lit.insert(lit.size(), CH_MINUS);
					if ($urandom_range(3) == 0) begin
						v = dec_edges[$urandom_range(0, 9)];
						s = $sformatf("%0d", v);
						for (int i = 0; i < s.len(); i++)
							lit.insert(lit.size(), s[i]);
					end else begin
						len = ($urandom_range(5) == 0) ? $urandom_range(9, 12) :
							$urandom_range(1, 5);
						repeat (len) lit.insert(lit.size(), 8'("0" + $urandom_range(0, 9)));
					end
				end
				LIT_BIN: begin
					lit.insert(lit.size(), CH_PERCENT);
					len = ($urandom_range(4) == 0) ? $urandom_range(30, 35) :
						$urandom_range(1, 8);
					repeat (len) lit.insert(lit.size(), 8'("0" + $urandom_range(0, 1)));
				end
				LIT_HEX: begin
					lit.insert(lit.size(), CH_DOLLAR);
					if ($urandom_range(4) == 0) begin
						s = $sformatf("%0h", hex_edges[$urandom_range(0, 5)]);
						for (int i = 0; i < s.len(); i++)
							lit.insert(lit.size(), s[i]);
					end else begin
						len = ($urandom_range(5) == 0) ? $urandom_range(8, 10) :
							$urandom_range(1, 4);
						repeat (len) lit.insert(lit.size(), 8'("0" + $urandom_range(0, 9)));
					end
					// Random letter case on every hex digit.
					for (int i = 1; i < lit.size(); i++) begin
						if ($urandom_range(2) == 0) begin
							d = $urandom_range(0, 5);
							lit[i] = ($urandom_range(1) == 0) ? 8'("a" + d) : 8'("A" + d);
						end else if (lit[i] >= "a" && lit[i] <= "f"
								&& $urandom_range(1) == 0) begin
							lit[i] = lit[i] - 8'd32;
						end
					end
				end
				LIT_NOISE: begin
					len = $urandom_range(1, 5);
					repeat (len) lit.insert(lit.size(), 8'($urandom_range(0, 255)));
				end
				default: begin
					// A prefix followed by something that is not a digit of it.
					case ($urandom_range(0, 3))
						0: lit.insert(lit.size(), CH_MINUS);
						1: lit.insert(lit.size(), CH_PERCENT);
						2: lit.insert(lit.size(), CH_DOLLAR);
						default: ;
					endcase
					case ($urandom_range(0, 3))
						0: lit.insert(lit.size(), CH_PERCENT);
						1: lit.insert(lit.size(), CH_DOLLAR);
						2: lit.insert(lit.size(), 8'("g" + $urandom_range(0, 19)));
						default: lit.insert(lit.size(), 8'("G" + $urandom_range(0, 19)));
					endcase
					if ($urandom_range(1) == 0)
						lit.insert(lit.size(), 8'("0" + $urandom_range(0, 9)));
				end
			endcase
			// Trailing characters that the block must ignore.
			if ($urandom_range(3) == 0) begin
				len = $urandom_range(1, 4);
				repeat (len) lit.insert(lit.size(), 8'($urandom_range(0, 255)));
			end
			send_bytes(lit);
		end
	endtask

	// Receiver side: out_ready follows a pattern that changes now and then.
	always @(posedge clk) begin
		if (rcv_left == 0) begin
			rcv_mode = rcv_mode_t'($urandom_range(0, 3));
			rcv_left = $urandom_range(10, 60);
		end
		rcv_left--;
		case (rcv_mode)
			RCV_ALWAYS:     out_ready <= 1'b1;
			RCV_HALF:       out_ready <= 1'($urandom_range(0, 1));
			RCV_SPARSE:     out_ready <= ($urandom_range(0, 3) == 0);
			default:        out_ready <= (rcv_left % 16 == 0);
		endcase
	end

	// Result check against the oldest expected value.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			n_results++;
			case (out_data.status)
				ST_OK:         n_ok++;
				ST_RANGE:      n_range++;
				ST_BAD_FORMAT: n_bad++;
				default: ;
			endcase
			if (literal_values_q.size() == 0) begin
				report_mismatch($sformatf("unexpected result: value %h status %0d",
					out_data.value_bits, out_data.status));
			end else begin
				want_res = literal_values_q.pop_front();
				if (out_data.value_bits !== want_res.value_bits)
					report_mismatch($sformatf("value %h, expected %h",
						out_data.value_bits, want_res.value_bits));
				if (out_data.status !== want_res.status)
					report_mismatch($sformatf("status %0d, expected %0d",
						out_data.status, want_res.status));
			end
		end
	end

	// Test sequence.
	initial begin
		int unsigned waited;
		waited = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_no_digits();
		test_radix_digits();
		test_literal_end();
		test_random_literals();
		in_valid <= 1'b0;

		// Wait for the outstanding results, then run a short tail before the check.
		while (literal_values_q.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (TAIL_CYCLES) @(posedge clk);
		if (literal_values_q.size() != 0)
			report_mismatch($sformatf("%0d expected results never arrived",
				literal_values_q.size()));

		$display("Sent %0d characters; checked %0d results (%0d ok, %0d out of range, %0d bad).",
			n_chars, n_results, n_ok, n_range, n_bad);
		$display("Covered binary, hex and decimal literals, boundaries and malformed input.");
		if (n_errors == 0) begin
			$display("tb_radix_prefixed_number_parser: done, clean");
		end else begin
			$display("tb_radix_prefixed_number_parser: done, errors");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/rpnp_pkg.sv
rtl/core/radix_prefixed_number_parser.sv
sim/tb_radix_prefixed_number_parser.sv
